// ===== src/mobt_pkg.sv =====
// shared types, sizes and codes for the booking overlap tracker
// no dependencies

package mobt_pkg;

  localparam int MAX_BOOKINGS = 64;
  localparam int TIME_BITS    = 32;
  localparam int DEPTH        = 2 * MAX_BOOKINGS;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int OVL_W        = 7;
  localparam int STATUS_W     = 2;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [TIME_BITS-1:0] t;
    logic                 opens;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     key;
  } cell_ctrl_t;

endpackage

// ===== src/mobt_cell.sv =====
// one slot of the sorted boundary chain: parallel insert or ring rotate
// depends on mobt_pkg

module mobt_cell import mobt_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       valid,
  input  entry_t     prev_ent,
  input  logic       prev_gt,
  input  entry_t     next_ent,
  output entry_t     ent,
  output logic       gt
);

  entry_t ent_r;
  entry_t ent_nxt;

  assign ent = ent_r;

  // strict order, ends before starts at equal times
  assign gt = valid && ((ent_r.t > ctrl.key.t) ||
                        ((ent_r.t == ctrl.key.t) && ent_r.opens && !ctrl.key.opens));

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (prev_gt) begin
          ent_nxt = prev_ent;
        end else if (gt || !valid) begin
          ent_nxt = ctrl.key;
        end
      end
      OP_ROTATE: begin
        ent_nxt = next_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== src/max_overlap_booking_tracker_core.sv =====
// booking overlap tracker: a stored booking inserts its start boundary and then
// its end boundary into the cell chain (S_INS_S, S_INS_E), then one full ring
// rotation is read at the head cell (S_SWEEP) and the result is registered; a
// rejected item is answered in the following cycle. a new booking is taken only while idle.
// synchronous active-low reset empties the table and clears the maximum.
// the receiver cannot stall; each result is strobed for one cycle.

module max_overlap_booking_tracker_core import mobt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [TIME_BITS-1:0] in_start_time,
  input  logic [TIME_BITS-1:0] in_end_time,
  output logic                 out_valid,
  output logic [OVL_W-1:0]     out_max_overlap,
  output logic [STATUS_W-1:0]  out_status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_INS_S = 2'd1;
  localparam logic [1:0] S_INS_E = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [OVL_W-1:0]     best_r, best_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [OVL_W-1:0]     run_r, run_nxt;
  logic [TIME_BITS-1:0] s_r, s_nxt, e_r, e_nxt;
  logic [OVL_W-1:0]     out_max_r, out_max_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;

  cell_ctrl_t ctrl;
  entry_t     ents [DEPTH];
  logic       gts  [DEPTH];
  logic       valids [DEPTH];

  logic             active;
  logic [OVL_W-1:0] run_step;

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_max_overlap = out_max_r;
  assign out_status      = out_status_r;

  always_comb begin
    unique case (state_r)
      S_INS_S: ctrl.op = OP_INSERT;
      S_INS_E: ctrl.op = OP_INSERT;
      S_SWEEP: ctrl.op = OP_ROTATE;
      default: ctrl.op = OP_HOLD;
    endcase
    if (state_r == S_INS_S) begin
      ctrl.key.t     = s_r;
      ctrl.key.opens = 1'b1;
    end else begin
      ctrl.key.t     = e_r;
      ctrl.key.opens = 1'b0;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign valids[i] = (CNT_W'(i) < cnt_r);
      if (i == 0) begin : g_head
        mobt_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .valid    (valids[i]),
          .prev_ent (ctrl.key),
          .prev_gt  (1'b0),
          .next_ent (ents[i+1]),
          .ent      (ents[i]),
          .gt       (gts[i])
        );
      end else if (i == DEPTH - 1) begin : g_tail
        mobt_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .valid    (valids[i]),
          .prev_ent (ents[i-1]),
          .prev_gt  (gts[i-1]),
          .next_ent (ents[0]),
          .ent      (ents[i]),
          .gt       (gts[i])
        );
      end else begin : g_mid
        mobt_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .valid    (valids[i]),
          .prev_ent (ents[i-1]),
          .prev_gt  (gts[i-1]),
          .next_ent (ents[i+1]),
          .ent      (ents[i]),
          .gt       (gts[i])
        );
      end
    end
  endgenerate

  // head cell holds entry idx_r during the rotation
  assign active   = ({1'b0, idx_r} < cnt_r);
  assign run_step = ents[0].opens ? (run_r + OVL_W'(1)) : (run_r - OVL_W'(1));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    best_nxt       = best_r;
    out_valid_nxt  = 1'b0;
    idx_nxt        = idx_r;
    run_nxt        = run_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    out_max_nxt    = out_max_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          s_nxt = in_start_time;
          e_nxt = in_end_time;
          if (in_end_time <= in_start_time) begin
            out_valid_nxt  = 1'b1;
            out_max_nxt    = best_r;
            out_status_nxt = ST_EMPTY;
          end else if (cnt_r > CNT_W'(DEPTH - 2)) begin
            out_valid_nxt  = 1'b1;
            out_max_nxt    = best_r;
            out_status_nxt = ST_FULL;
          end else begin
            state_nxt = S_INS_S;
          end
        end
      end
      S_INS_S: begin
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_INS_E;
      end
      S_INS_E: begin
        cnt_nxt   = cnt_r + CNT_W'(1);
        idx_nxt   = '0;
        run_nxt   = '0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (active) begin
          run_nxt = run_step;
          if (run_step > best_r) begin
            best_nxt = run_step;
          end
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(DEPTH - 1)) begin
          out_valid_nxt  = 1'b1;
          out_max_nxt    = best_nxt;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    run_r        <= run_nxt;
    s_r          <= s_nxt;
    e_r          <= e_nxt;
    out_max_r    <= out_max_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
